// ===== rtl/sfpe_pkg.sv =====
// shared types, constants and step tables of the flash program and erase sequencer
package sfpe_pkg;

    localparam int unsigned ADDR_W  = 24;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;

    localparam logic [BYTE_W-1:0] PAGE_PROGRAM_OPCODE = 8'h02;

    localparam logic [2:0] REG_WREN = 3'd0;
    localparam logic [2:0] REG_WRDI = 3'd1;
    localparam logic [2:0] REG_SE   = 3'd2;
    localparam logic [2:0] REG_SRO  = 3'd3;
    localparam logic [2:0] REG_MASK = 3'd4;

    localparam logic [1:0] FUNC_PROGRAM = 2'd0;
    localparam logic [1:0] FUNC_ERASE   = 2'd1;
    localparam logic [1:0] FUNC_STATUS  = 2'd2;

    typedef enum logic [1:0] {
        ACT_SEL_LOW  = 2'd0,
        ACT_SEND     = 2'd1,
        ACT_RECV     = 2'd2,
        ACT_SEL_HIGH = 2'd3
    } t_action;

    typedef struct packed {
        logic [BYTE_W-1:0] wren;
        logic [BYTE_W-1:0] wrdi;
        logic [BYTE_W-1:0] se;
        logic [BYTE_W-1:0] sro;
        logic [BYTE_W-1:0] mask;
    } t_cfg;

    // one bus action of a job
    typedef enum logic [3:0] {
        ST_SL,
        ST_SH,
        ST_RECV,
        ST_WREN,
        ST_WRDI,
        ST_SE,
        ST_SRO,
        ST_PP,
        ST_A2,
        ST_A1,
        ST_A0,
        ST_DATA
    } t_step;

    typedef enum logic [2:0] {
        K_PD,
        K_PH,
        K_PT,
        K_PHT,
        K_ERASE,
        K_POLL,
        K_DONE,
        K_NEXT
    } t_kind;

    typedef t_step [0:15] t_seq;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_qout;

    function automatic t_seq kind_seq(input t_kind kind);
        t_seq s;
        case (kind)
            K_PD: begin
                s = '{ST_DATA, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL,
                      ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL};
            end
            K_PH: begin
                s = '{ST_SL, ST_WREN, ST_SH, ST_SL, ST_PP, ST_A2, ST_A1, ST_A0,
                      ST_DATA, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL};
            end
            K_PT: begin
                s = '{ST_DATA, ST_SH, ST_SL, ST_WRDI, ST_SH, ST_SL, ST_SL, ST_SL,
                      ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL};
            end
            K_PHT: begin
                s = '{ST_SL, ST_WREN, ST_SH, ST_SL, ST_PP, ST_A2, ST_A1, ST_A0,
                      ST_DATA, ST_SH, ST_SL, ST_WRDI, ST_SH, ST_SL, ST_SL, ST_SL};
            end
            K_ERASE: begin
                s = '{ST_SL, ST_WREN, ST_SH, ST_SL, ST_SE, ST_A2, ST_A1, ST_A0,
                      ST_SH, ST_SL, ST_SRO, ST_RECV, ST_SH, ST_SL, ST_SL, ST_SL};
            end
            K_POLL: begin
                s = '{ST_SL, ST_SRO, ST_RECV, ST_SH, ST_SL, ST_SL, ST_SL, ST_SL,
                      ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL};
            end
            K_DONE: begin
                s = '{ST_SL, ST_WRDI, ST_SH, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL,
                      ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL};
            end
            K_NEXT: begin
                s = '{ST_SL, ST_WRDI, ST_SH, ST_SL, ST_WREN, ST_SH, ST_SL, ST_SE,
                      ST_A2, ST_A1, ST_A0, ST_SH, ST_SL, ST_SRO, ST_RECV, ST_SH};
            end
            default: begin
                s = '{ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL,
                      ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL, ST_SL};
            end
        endcase
        return s;
    endfunction

    // index of the final step of a job
    function automatic logic [3:0] kind_last(input t_kind kind);
        logic [3:0] n;
        case (kind)
            K_PD:    n = 4'd0;
            K_PH:    n = 4'd8;
            K_PT:    n = 4'd4;
            K_PHT:   n = 4'd12;
            K_ERASE: n = 4'd12;
            K_POLL:  n = 4'd3;
            K_DONE:  n = 4'd2;
            K_NEXT:  n = 4'd15;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/sfpe_regs.sv =====
// configuration register file with its apb-style port
module sfpe_regs
    import sfpe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wren <= 8'h06;
            r_cfg.wrdi <= 8'h04;
            r_cfg.se   <= 8'h20;
            r_cfg.sro  <= 8'h05;
            r_cfg.mask <= 8'h01;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WREN: r_cfg.wren <= pwdata[BYTE_W-1:0];
                REG_WRDI: r_cfg.wrdi <= pwdata[BYTE_W-1:0];
                REG_SE:   r_cfg.se   <= pwdata[BYTE_W-1:0];
                REG_SRO:  r_cfg.sro  <= pwdata[BYTE_W-1:0];
                REG_MASK: r_cfg.mask <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_WREN: prdata = {{(PDATA_W-BYTE_W){1'b0}}, r_cfg.wren};
            REG_WRDI: prdata = {{(PDATA_W-BYTE_W){1'b0}}, r_cfg.wrdi};
            REG_SE:   prdata = {{(PDATA_W-BYTE_W){1'b0}}, r_cfg.se};
            REG_SRO:  prdata = {{(PDATA_W-BYTE_W){1'b0}}, r_cfg.sro};
            REG_MASK: prdata = {{(PDATA_W-BYTE_W){1'b0}}, r_cfg.mask};
            default:  prdata = '0;
        endcase
    end

endmodule

// ===== rtl/sfpe_front.sv =====
// front end: accepts requests, tracks transfer and erase state, issues jobs
module sfpe_front
    import sfpe_pkg::*;
#(
    parameter int unsigned CHUNK_BYTES  = 256,
    parameter int unsigned SECTOR_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_func,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [ADDR_W-1:0] i_length,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last,
    input  logic              i_q_full,
    output logic              o_push,
    output t_job              o_job
);

    localparam int unsigned CW = $clog2(CHUNK_BYTES + 1);

    logic              r_tx_open;
    logic              r_chunk_open;
    logic [CW-1:0]     r_count;
    logic [ADDR_W-1:0] r_prog_addr;
    logic [ADDR_W-1:0] r_erase_addr;
    logic [ADDR_W-1:0] r_erase_rem;
    logic              r_await;

    logic              n_tx_open;
    logic              n_chunk_open;
    logic [CW-1:0]     n_count;
    logic [ADDR_W-1:0] n_prog_addr;
    logic [ADDR_W-1:0] n_erase_addr;
    logic [ADDR_W-1:0] n_erase_rem;
    logic              n_await;

    logic              accept;
    logic              hdr;
    logic              close;
    logic [ADDR_W-1:0] paddr_cur;
    logic [CW-1:0]     cnt_next;
    logic [ADDR_W-1:0] next_sector;

    assign o_ready     = !i_q_full;
    assign accept      = i_valid & o_ready;
    assign hdr         = !r_tx_open || !r_chunk_open;
    assign paddr_cur   = r_tx_open ? r_prog_addr : i_address;
    assign cnt_next    = (hdr ? '0 : r_count) + CW'(1);
    assign close       = (cnt_next >= CW'(CHUNK_BYTES)) || i_last;
    assign next_sector = r_erase_addr + ADDR_W'(SECTOR_BYTES);

    always_comb begin
        n_tx_open    = r_tx_open;
        n_chunk_open = r_chunk_open;
        n_count      = r_count;
        n_prog_addr  = r_prog_addr;
        n_erase_addr = r_erase_addr;
        n_erase_rem  = r_erase_rem;
        n_await      = r_await;
        o_push       = 1'b0;
        o_job.kind   = K_PD;
        o_job.addr   = paddr_cur;
        o_job.data   = i_data_byte;
        case (i_func)
            FUNC_PROGRAM: begin
                if (!r_await) begin
                    o_push       = accept;
                    o_job.kind   = hdr ? (close ? K_PHT : K_PH) : (close ? K_PT : K_PD);
                    n_tx_open    = !i_last;
                    n_chunk_open = !close;
                    n_count      = close ? '0 : cnt_next;
                    n_prog_addr  = paddr_cur + ADDR_W'(1);
                end
            end
            FUNC_ERASE: begin
                if (!r_tx_open && !r_await && (i_length != '0)) begin
                    o_push       = accept;
                    o_job.kind   = K_ERASE;
                    o_job.addr   = i_address;
                    n_erase_addr = i_address;
                    n_erase_rem  = i_length;
                    n_await      = 1'b1;
                end
            end
            FUNC_STATUS: begin
                if (r_await) begin
                    o_push = accept;
                    if ((i_data_byte & i_cfg.mask) != '0) begin
                        o_job.kind = K_POLL;
                    end else if (r_erase_rem <= ADDR_W'(SECTOR_BYTES)) begin
                        o_job.kind  = K_DONE;
                        n_erase_rem = '0;
                        n_await     = 1'b0;
                    end else begin
                        o_job.kind   = K_NEXT;
                        o_job.addr   = next_sector;
                        n_erase_addr = next_sector;
                        n_erase_rem  = r_erase_rem - ADDR_W'(SECTOR_BYTES);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_open    <= 1'b0;
            r_chunk_open <= 1'b0;
            r_count      <= '0;
            r_prog_addr  <= '0;
            r_erase_addr <= '0;
            r_erase_rem  <= '0;
            r_await      <= 1'b0;
        end else if (accept) begin
            r_tx_open    <= n_tx_open;
            r_chunk_open <= n_chunk_open;
            r_count      <= n_count;
            r_prog_addr  <= n_prog_addr;
            r_erase_addr <= n_erase_addr;
            r_erase_rem  <= n_erase_rem;
            r_await      <= n_await;
        end
    end

endmodule

// ===== rtl/sfpe_queue.sv =====
// job queue between front end and bus sequencer
module sfpe_queue
    import sfpe_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_job,
    output logic  o_full,
    input  logic  i_pop,
    output t_qout o_q
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [NW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full    = (r_cnt == NW'(DEPTH));
    assign o_q.valid = (r_cnt != '0);
    assign o_q.job   = r_mem[r_rd];
    assign do_push   = i_push & !o_full;
    assign do_pop    = i_pop & o_q.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

endmodule

// ===== rtl/sfpe_back.sv =====
// bus sequencer: expands each job into select, send and receive actions
module sfpe_back
    import sfpe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_qout             i_q,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_action,
    output logic [BYTE_W-1:0] o_byte_out,
    output logic              o_last_of_run
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state            r_state;
    t_job              r_job;
    logic [3:0]        r_idx;
    logic              r_valid;
    t_action           r_action;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    t_seq              seq;
    t_step             step;
    logic [3:0]        last_idx;
    logic              adv;
    t_action           n_action;
    logic [BYTE_W-1:0] n_byte;

    assign seq      = kind_seq(r_job.kind);
    assign step     = seq[r_idx];
    assign last_idx = kind_last(r_job.kind);
    assign adv      = (r_state == S_RUN) && (!r_valid || i_ready);
    assign o_pop    = (r_state == S_IDLE) && i_q.valid;

    assign o_valid       = r_valid;
    assign o_action      = r_action;
    assign o_byte_out    = r_byte;
    assign o_last_of_run = r_last;

    always_comb begin
        n_action = ACT_SEND;
        n_byte   = '0;
        case (step)
            ST_SL:   n_action = ACT_SEL_LOW;
            ST_SH:   n_action = ACT_SEL_HIGH;
            ST_RECV: n_action = ACT_RECV;
            ST_WREN: n_byte   = i_cfg.wren;
            ST_WRDI: n_byte   = i_cfg.wrdi;
            ST_SE:   n_byte   = i_cfg.se;
            ST_SRO:  n_byte   = i_cfg.sro;
            ST_PP:   n_byte   = PAGE_PROGRAM_OPCODE;
            ST_A2:   n_byte   = r_job.addr[23:16];
            ST_A1:   n_byte   = r_job.addr[15:8];
            ST_A0:   n_byte   = r_job.addr[7:0];
            ST_DATA: n_byte   = r_job.data;
            default: n_action = ACT_SEL_LOW;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q.valid) begin
                        r_job   <= i_q.job;
                        r_idx   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (adv) begin
                        r_idx <= r_idx + 4'd1;
                        if (r_idx == last_idx) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (adv) begin
                r_valid  <= 1'b1;
                r_action <= n_action;
                r_byte   <= n_byte;
                r_last   <= (r_idx == last_idx);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/spi_flash_program_erase_sequencer.sv =====
// top level of the spi nor flash program and erase sequencer
// input channel: one transfer per request (program data byte, erase request or
// returned status byte) on i_in_valid / o_in_ready
// output channel: one transfer per bus action (select low, send byte, receive
// byte, select high) on o_out_valid / i_out_ready; o_last_of_run marks the
// final action caused by one request
// the front end takes one request per cycle while the job queue has room; each
// request becomes at most one job of up to 16 actions
// the bus sequencer issues one action per cycle while the receiver takes them,
// with an idle state between jobs; a request passes through the job queue,
// the job register and the output register before its first action appears
// a stalled receiver holds the output register; the queue (QUEUE_DEPTH jobs)
// then fills and o_in_ready drops
// reset clears all transfer and erase state, empties the queue and loads the
// default opcodes and busy mask; registers are written over the apb port
module spi_flash_program_erase_sequencer
    import sfpe_pkg::*;
#(
    parameter int unsigned CHUNK_BYTES  = 256,
    parameter int unsigned SECTOR_BYTES = 4096,
    parameter int unsigned QUEUE_DEPTH  = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic [ADDR_W-1:0]  i_address,
    input  logic [ADDR_W-1:0]  i_length,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_action,
    output logic [BYTE_W-1:0]  o_byte_out,
    output logic               o_last_of_run
);

    t_cfg  cfg;
    logic  q_full;
    logic  push;
    t_job  job;
    logic  pop;
    t_qout q_out;

    sfpe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sfpe_front #(
        .CHUNK_BYTES  (CHUNK_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_func      (i_func),
        .i_address   (i_address),
        .i_length    (i_length),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (job)
    );

    sfpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_q     (q_out)
    );

    sfpe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q           (q_out),
        .o_pop         (pop),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_action      (o_action),
        .o_byte_out    (o_byte_out),
        .o_last_of_run (o_last_of_run)
    );

endmodule
